// File: hdl/tt_pkg.sv
// Shared types, codes and character helpers for the text tokenizer.
`default_nettype none
package tt_pkg;

    localparam int POS_BITS = 16;

    localparam int KIND_BITS = 3;

    // token kinds
    localparam logic [KIND_BITS-1:0] KIND_WORD   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_FUNC   = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_EQUAL  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_COMMA  = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE = 3'd6;
    localparam logic [KIND_BITS-1:0] KIND_UNREC  = 3'd7;

    // scan modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;

    // keyword match progress
    localparam logic [2:0] KW_NONE = 3'd0;
    localparam logic [2:0] KW_FULL = 3'd4;
    localparam logic [2:0] KW_DEAD = 3'd7;

    typedef logic [POS_BITS-1:0]  t_pos;
    typedef logic [KIND_BITS-1:0] t_kind;

    typedef struct packed {
        logic  is_alpha;
        logic  is_digit;
        logic  is_space;
        logic  is_single;   // one-byte token or unrecognized byte
        t_kind single_kind;
    } t_cls;

    typedef struct packed {
        t_kind kind;
        t_pos  start;
        t_pos  length;
        logic  last;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;    // results produced by this beat, 0..2
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic [7:0] kw_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h66;  // f
            2'd1:    ch = 8'h75;  // u
            2'd2:    ch = 8'h6E;  // n
            default: ch = 8'h63;  // c
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] kw_next(input logic [2:0] kw, input logic [7:0] c);
        logic [2:0] nk;
        if (kw < KW_FULL && c == kw_char(kw[1:0])) begin
            nk = kw + 3'd1;
        end else begin
            nk = KW_DEAD;
        end
        return nk;
    endfunction

    function automatic t_kind closed_kind(input logic [1:0] mode, input logic [2:0] kw);
        t_kind k;
        if (mode == MODE_NUMBER) begin
            k = KIND_NUMBER;
        end else if (kw == KW_FULL) begin
            k = KIND_FUNC;
        end else begin
            k = KIND_WORD;
        end
        return k;
    endfunction

endpackage
`default_nettype wire

// File: hdl/tt_class.sv
// Byte classifier: letter, digit, whitespace, single-byte tokens.
`default_nettype none
module tt_class (
    input  wire logic [7:0]  i_byte,
    output tt_pkg::t_cls     o_cls
);
    import tt_pkg::*;

    always_comb begin
        o_cls.is_alpha    = i_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        o_cls.is_digit    = i_byte inside {[8'h30:8'h39]};
        o_cls.is_space    = i_byte inside {8'h20, [8'h09:8'h0D]};
        o_cls.is_single   = !(o_cls.is_alpha || o_cls.is_digit || o_cls.is_space);
        case (i_byte)
            8'h3D:   o_cls.single_kind = KIND_EQUAL;
            8'h2C:   o_cls.single_kind = KIND_COMMA;
            8'h7B:   o_cls.single_kind = KIND_LBRACE;
            8'h7D:   o_cls.single_kind = KIND_RBRACE;
            default: o_cls.single_kind = KIND_UNREC;
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/tt_scan.sv
// Scanner state and per-beat result formation (up to two results).
`default_nettype none
module tt_scan (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_acc,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_end,
    input  tt_pkg::t_cls     i_cls,
    output tt_pkg::t_push    o_push
);
    import tt_pkg::*;

    logic [1:0] r_mode, n_mode;
    t_pos       r_ost,  n_ost;
    t_pos       r_pos,  n_pos;
    logic [2:0] r_kw,   n_kw;

    logic                 open_old;
    logic                 keep;
    t_pos                 diff;
    logic [POS_BITS:0]    len_end;
    t_result              res_close, res_single, res_end;
    logic                 do_close, do_single, do_end;

    always_comb begin
        open_old = (r_mode == MODE_WORD) || (r_mode == MODE_NUMBER);
        keep     = (r_mode == MODE_WORD && (i_cls.is_alpha || i_cls.is_digit)) ||
                   (r_mode == MODE_NUMBER && i_cls.is_digit);

        n_mode = r_mode;
        n_ost  = r_ost;
        n_kw   = r_kw;

        // close of the token open before this byte
        diff              = r_pos - r_ost;
        do_close          = !keep && open_old;
        res_close.kind    = closed_kind(r_mode, r_kw);
        res_close.start   = r_ost;
        res_close.length  = (diff == '0) ? t_pos'(1) : diff;
        res_close.last    = 1'b0;

        do_single         = 1'b0;
        res_single.kind   = i_cls.single_kind;
        res_single.start  = r_pos;
        res_single.length = t_pos'(1);
        res_single.last   = 1'b0;

        if (keep) begin
            if (r_mode == MODE_WORD) begin
                n_kw = kw_next(r_kw, i_byte);
            end
        end else begin
            n_mode = MODE_IDLE;
            n_kw   = KW_NONE;
            if (i_cls.is_alpha) begin
                n_mode = MODE_WORD;
                n_ost  = r_pos;
                n_kw   = kw_next(KW_NONE, i_byte);
            end else if (i_cls.is_digit) begin
                n_mode = MODE_NUMBER;
                n_ost  = r_pos;
            end else begin
                do_single = i_cls.is_single;
            end
        end

        // end of text closes whatever is open, including this byte
        len_end         = {1'b0, r_pos} - {1'b0, n_ost} + {{POS_BITS{1'b0}}, 1'b1};
        do_end          = i_end && ((n_mode == MODE_WORD) || (n_mode == MODE_NUMBER));
        res_end.kind    = closed_kind(n_mode, n_kw);
        res_end.start   = n_ost;
        res_end.length  = len_end[POS_BITS] ? '1 : len_end[POS_BITS-1:0];
        res_end.last    = 1'b0;

        o_push.cnt  = 2'd0;
        o_push.res0 = res_close;
        o_push.res1 = res_single;
        if (do_close) begin
            o_push.cnt = 2'd1;
            if (do_single) begin
                o_push.cnt  = 2'd2;
                o_push.res1 = res_single;
            end else if (do_end) begin
                o_push.cnt  = 2'd2;
                o_push.res1 = res_end;
            end
        end else if (do_single) begin
            o_push.cnt  = 2'd1;
            o_push.res0 = res_single;
        end else if (do_end) begin
            o_push.cnt  = 2'd1;
            o_push.res0 = res_end;
        end
        o_push.res0.last = (o_push.cnt == 2'd1);
        o_push.res1.last = 1'b1;
        if (!i_acc) begin
            o_push.cnt = 2'd0;
        end

        n_pos = (r_pos == '1) ? r_pos : r_pos + t_pos'(1);
        if (i_end) begin
            n_mode = MODE_IDLE;
            n_ost  = '0;
            n_kw   = KW_NONE;
            n_pos  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_ost  <= '0;
            r_pos  <= '0;
            r_kw   <= KW_NONE;
        end else if (i_acc) begin
            r_mode <= n_mode;
            r_ost  <= n_ost;
            r_pos  <= n_pos;
            r_kw   <= n_kw;
        end
    end

endmodule
`default_nettype wire

// File: hdl/tt_rbuf.sv
// Four-entry result queue; takes up to two results per beat, sends one.
`default_nettype none
module tt_rbuf (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  tt_pkg::t_push    i_push,
    output logic             o_in_ready,
    output logic             o_valid,
    input  wire logic        i_ready,
    output tt_pkg::t_result  o_res
);
    import tt_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count;
    logic       pop;

    assign o_in_ready = (r_count <= 3'd2);
    assign o_valid    = (r_count != 3'd0);
    assign o_res      = r_mem[r_rd];
    assign pop        = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + i_push.cnt;
            r_rd    <= r_rd + {1'b0, pop};
            r_count <= r_count + {1'b0, i_push.cnt} - {2'b00, pop};
        end
    end

endmodule
`default_nettype wire

// File: hdl/ir_text_tokenizer.sv
// Top level of the IR text tokenizer: byte stream in, token records out.
// A closed token is registered into the four-entry result queue and shows
//   on o_valid once the tokens ahead of it have been taken. Throughput: one
//   input beat per cycle while each byte yields at most one token and i_ready
//   holds; two tokens from one byte leave one at a time by the single output port.
// Reset: synchronous active-low i_rst_n clears scan mode, positions, keyword
//   progress and the result queue.
`default_nettype none
module ir_text_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte stream
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_text_end,
    // token stream
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_token_kind,
    output logic [15:0]      o_token_start,
    output logic [15:0]      o_token_length,
    output logic             o_run_last
);
    import tt_pkg::*;

    t_cls    w_cls;
    t_push   w_push;
    t_result w_res;
    logic    w_acc;

    // a beat is taken only when the queue can hold two more results
    assign w_acc = i_valid && o_ready;

    tt_class u_class (
        .i_byte (i_text_byte),
        .o_cls  (w_cls)
    );

    // mode, open-token start, position and keyword match live here
    tt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_byte  (i_text_byte),
        .i_end   (i_text_end),
        .i_cls   (w_cls),
        .o_push  (w_push)
    );

    // result queue decouples the two sides
    tt_rbuf u_rbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_in_ready (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (w_res)
    );

    assign o_token_kind   = w_res.kind;
    assign o_token_start  = w_res.start;
    assign o_token_length = w_res.length;
    assign o_run_last     = w_res.last;

    // nothing is pushed without an accepted beat
    a_push_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |-> (w_push.cnt == 2'd0))
        else $error("results pushed without an input beat");

    // a beat never yields more than two results
    a_push_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.cnt != 2'd3)
        else $error("more than two results for one beat");

    // run_last marks only the final result of a beat
    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt == 2'd1) |-> w_push.res0.last)
        else $error("lone result lacks run_last");

    a_last_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt == 2'd2) |-> (!w_push.res0.last && w_push.res1.last))
        else $error("run_last misplaced on result pair");

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for ir_text_tokenizer: byte stream in, token records checked out.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tt_pkg::*;

    localparam int CLK_PERIOD  = 10;
    // About 1300 beats; even with every gap and stall at its longest and two
    // tokens per beat a correct run stays well under this limit.
    localparam int CYCLE_LIMIT = 400_000;
    localparam int RANDOM_BYTES = 1225;  // total bytes sent before the random texts stop
    localparam int QUIET_FROM   = 1000;  // bytes sent after which idling stops
    localparam int PAUSE_AT     = 600;   // bytes sent before the full drain

    localparam logic [31:0] FUNC_WORD = "func";
    localparam logic [7:0]  CH_EQUAL  = "=";
    localparam logic [7:0]  CH_COMMA  = ",";
    localparam logic [7:0]  CH_LBRACE = "{";
    localparam logic [7:0]  CH_RBRACE = "}";
    localparam logic [7:0]  CH_SPACE  = " ";

    // DUT ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [7:0]  i_text_byte = 8'h00;
    logic        i_text_end  = 1'b0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [2:0]  o_token_kind;
    logic [15:0] o_token_start;
    logic [15:0] o_token_length;
    logic        o_run_last;

    // Scanner shadow state, advanced once per accepted byte beat
    logic [1:0]  scan_mode = MODE_IDLE;
    t_pos        tok_start = '0;
    t_pos        byte_pos  = '0;
    logic [2:0]  kw_prog   = KW_NONE;

    // Tokens predicted but not yet seen on the output, oldest first
    t_result     pending_tokens [$];

    bit          idle_on      = 1'b1;   // random gaps and stalls enabled
    int          ready_hold   = 0;      // remaining stall cycles on i_ready
    int          cycle_count  = 0;
    int          err_count    = 0;
    int          bytes_sent   = 0;
    int          tokens_seen  = 0;
    int          pair_beats   = 0;      // beats that closed two tokens
    logic [7:0]  kinds_seen   = '0;

    ir_text_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_text_byte    (i_text_byte),
        .i_text_end     (i_text_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_run_last     (o_run_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost token ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d tokens still pending",
                     cycle_count, pending_tokens.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Character classes and token shadow model
    // ---------------------------------------------------------------
    function automatic bit is_letter(input logic [7:0] ch);
        return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
    endfunction

    function automatic bit is_digit(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    // space, tab, LF, VT, FF, CR
    function automatic bit is_blank(input logic [7:0] ch);
        return ch == CH_SPACE || (ch >= 8'h09 && ch <= 8'h0D);
    endfunction

    // One more letter of "func" matched, or the word is no longer a keyword.
    function automatic logic [2:0] func_match(input logic [2:0] prog, input logic [7:0] ch);
        if (prog < KW_FULL && ch == FUNC_WORD[8 * (3 - int'(prog)) +: 8]) begin
            return prog + 3'd1;
        end
        return KW_DEAD;
    endfunction

    function automatic t_kind open_kind();
        if (scan_mode == MODE_NUMBER) begin
            return KIND_NUMBER;
        end
        return (kw_prog == KW_FULL) ? KIND_FUNC : KIND_WORD;
    endfunction

    // Lengths above the 16-bit field clamp to all ones.
    function automatic t_result make_token(input t_kind kind, input t_pos start, input int len);
        t_result tok;
        tok.kind   = kind;
        tok.start  = start;
        tok.length = (len > 65535) ? 16'hFFFF : 16'(len);
        tok.last   = 1'b0;
        return tok;
    endfunction

    // Advance the shadow scanner by one byte and queue the tokens it closes.
    function automatic void scan_byte(input logic [7:0] ch, input logic last_byte);
        t_result found [2];
        int      n;
        int      span;
        int      i;
        t_pos    here;
        n    = 0;
        here = byte_pos;
        if (scan_mode == MODE_WORD && (is_letter(ch) || is_digit(ch))) begin
            kw_prog = func_match(kw_prog, ch);
        end else if (scan_mode == MODE_NUMBER && is_digit(ch)) begin
            // number runs on
        end else begin
            // anything else closes an open token; a saturated position can
            // give a zero span, which still reports as one byte
            if (scan_mode == MODE_WORD || scan_mode == MODE_NUMBER) begin
                span     = int'(here) - int'(tok_start);
                found[n] = make_token(open_kind(), tok_start, (span == 0) ? 1 : span);
                n++;
            end
            scan_mode = MODE_IDLE;
            kw_prog   = KW_NONE;
            if (is_letter(ch)) begin
                scan_mode = MODE_WORD;
                tok_start = here;
                kw_prog   = func_match(KW_NONE, ch);
            end else if (is_digit(ch)) begin
                scan_mode = MODE_NUMBER;
                tok_start = here;
            end else if (ch == CH_EQUAL) begin
                found[n] = make_token(KIND_EQUAL, here, 1);
                n++;
            end else if (ch == CH_COMMA) begin
                found[n] = make_token(KIND_COMMA, here, 1);
                n++;
            end else if (ch == CH_LBRACE) begin
                found[n] = make_token(KIND_LBRACE, here, 1);
                n++;
            end else if (ch == CH_RBRACE) begin
                found[n] = make_token(KIND_RBRACE, here, 1);
                n++;
            end else if (!is_blank(ch)) begin
                found[n] = make_token(KIND_UNREC, here, 1);
                n++;
            end
        end
        // end of text closes the open token including this byte, then the
        // scanner starts over at position zero
        if (last_byte) begin
            if (scan_mode == MODE_WORD || scan_mode == MODE_NUMBER) begin
                found[n] = make_token(open_kind(), tok_start,
                                      int'(here) - int'(tok_start) + 1);
                n++;
            end
            scan_mode = MODE_IDLE;
            tok_start = '0;
            byte_pos  = '0;
            kw_prog   = KW_NONE;
        end else if (byte_pos != '1) begin
            byte_pos++;
        end
        if (n == 2) begin
            pair_beats++;
        end
        for (i = 0; i < n; i++) begin
            found[i].last = (i == n - 1);
            pending_tokens.push_back(found[i]);
        end
    endfunction

    // ---------------------------------------------------------------
    // Mismatch reporting and the token checker
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 100) begin
            $display("tb: MISMATCH at cycle %0d: %s", cycle_count, what);
        end
    endtask

    // Every output beat is matched against the oldest predicted token.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            kinds_seen[o_token_kind] = 1'b1;
            if (pending_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind %0d start %0d length %0d",
                                          o_token_kind, o_token_start, o_token_length));
            end else begin
                want = pending_tokens.pop_front();
                if (o_token_kind !== want.kind)
                    report_mismatch($sformatf("token %0d kind: expected %0d, got %0d",
                                              tokens_seen, want.kind, o_token_kind));
                if (o_token_start !== want.start)
                    report_mismatch($sformatf("token %0d start: expected %0d, got %0d",
                                              tokens_seen, want.start, o_token_start));
                if (o_token_length !== want.length)
                    report_mismatch($sformatf("token %0d length: expected %0d, got %0d",
                                              tokens_seen, want.length, o_token_length));
                if (o_run_last !== want.last)
                    report_mismatch($sformatf("token %0d run_last: expected %0d, got %0d",
                                              tokens_seen, want.last, o_run_last));
            end
            tokens_seen++;
        end
    end

    // Token sink: random stall bursts on i_ready while idling is on.
    always @(negedge i_clk) begin
        if (!idle_on) begin
            ready_hold = 0;
            i_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_hold = $urandom_range(1, 17) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Byte source
    // ---------------------------------------------------------------
    // Entered and left at a falling edge. Valid stays high into the next
    // call so back-to-back beats flow; any pause lowers it first.
    task automatic send_text_byte(input logic [7:0] ch, input logic last_byte);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= ch;
        i_text_end  <= last_byte;
        do @(posedge i_clk); while (!o_ready);
        scan_byte(ch, last_byte);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string text, input bit end_text);
        int i;
        for (i = 0; i < text.len(); i++) begin
            send_text_byte(text[i], end_text && (i == text.len() - 1));
        end
    endtask

    // Hold the source off until every predicted token has come out.
    // Leaves at a later falling edge than the one that lowered valid.
    task automatic wait_all_tokens();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_tokens.size() != 0) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Keyword match is exact and case sensitive; a closing punctuation
    // byte yields the word and its own token on the same beat.
    task automatic test_keyword();
        send_text("func=", 1'b0);
        send_text("Func,", 1'b0);
        send_text("fun ", 1'b0);
    endtask

    // Braces around a number: the closing brace ends the number too.
    task automatic test_braces_numbers();
        send_text("{9}", 1'b0);
    endtask

    // Byte extremes and whitespace; the text ends on a blank.
    task automatic test_byte_extremes();
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h09, 1'b0);
        send_text_byte(8'h0D, 1'b0);
        send_text_byte(CH_SPACE, 1'b1);
    endtask

    // Number then letter on the final byte: number plus one-byte word.
    task automatic test_end_of_text();
        send_text("7a", 1'b1);
    endtask

    function automatic logic [7:0] rand_alnum();
        case ($urandom_range(0, 2))
            0:       return 8'h61 + 8'($urandom_range(0, 25));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            default: return 8'h30 + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // One text of random pieces, mostly well formed, ending with the end flag.
    task automatic send_random_text();
        logic [7:0] text_q [$];
        string      kw_text;
        int         pieces;
        int         p;
        int         i;
        pieces = $urandom_range(1, 12);
        for (p = 0; p < pieces; p++) begin
            case ($urandom_range(0, 7))
                0, 1: begin
                    text_q.push_back(is_letter(rand_alnum()) ? rand_alnum() : 8'h7A);
                    repeat ($urandom_range(0, 6)) text_q.push_back(rand_alnum());
                end
                2: begin
                    case ($urandom_range(0, 4))
                        0, 1:    kw_text = "func";
                        2:       kw_text = "fun";
                        3:       kw_text = "funcs";
                        default: kw_text = "Func";
                    endcase
                    for (i = 0; i < kw_text.len(); i++) text_q.push_back(kw_text[i]);
                end
                3: begin
                    repeat ($urandom_range(1, 5)) text_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
                end
                4: begin
                    case ($urandom_range(0, 3))
                        0:       text_q.push_back(CH_EQUAL);
                        1:       text_q.push_back(CH_COMMA);
                        2:       text_q.push_back(CH_LBRACE);
                        default: text_q.push_back(CH_RBRACE);
                    endcase
                end
                5, 6: begin
                    repeat ($urandom_range(1, 3)) begin
                        text_q.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE
                                         : 8'h09 + 8'($urandom_range(0, 4)));
                    end
                end
                default: text_q.push_back(8'($urandom_range(0, 255)));  // noise
            endcase
            if ($urandom_range(0, 1) == 0) text_q.push_back(CH_SPACE);
        end
        for (i = 0; i < text_q.size(); i++) begin
            send_text_byte(text_q[i], i == text_q.size() - 1);
        end
    endtask

    // Random texts: idling early, one full drain midway, quiet at the end.
    task automatic test_random_texts();
        bit  drained;
        drained = 1'b0;
        while (bytes_sent < RANDOM_BYTES) begin
            if (!drained && bytes_sent >= PAUSE_AT) begin
                wait_all_tokens();
                drained = 1'b1;
            end
            if (bytes_sent >= QUIET_FROM) idle_on = 1'b0;
            send_random_text();
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_keyword();
        test_braces_numbers();
        test_byte_extremes();
        test_end_of_text();
        test_random_texts();

        wait_all_tokens();
        repeat (4) @(posedge i_clk);

        $display("tb: %0d bytes scanned, %0d tokens checked, %0d beats closed two tokens",
                 bytes_sent, tokens_seen, pair_beats);
        $display("tb: token kinds seen (bit per kind) %b, with random gaps and stalls",
                 kinds_seen);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/tt_pkg.sv
hdl/tt_class.sv
hdl/tt_scan.sv
hdl/tt_rbuf.sv
hdl/ir_text_tokenizer.sv
tb/tb.sv
